// ===== rtl/core/dht_pkg.sv =====
package dht_pkg;

   localparam int DEF_TABLE_DEPTH = 16;
   localparam int DEF_STEP_PRIME  = 7;

   localparam int KEY_W   = 32;
   localparam int VAL_W   = 32;
   localparam int STAT_W  = 3;
   localparam int SLOT_W  = 4;
   localparam int STEP_W  = 8;   // holds any step up to 255
   localparam int OPND_W  = 32;

   // request kinds
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_SEARCH = 1'b1;

   // response status codes
   localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STAT_W-1:0] ST_UPDATED   = 3'd1;
   localparam logic [STAT_W-1:0] ST_FOUND     = 3'd2;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

   // microprogram step addresses
   localparam int STEP_CODE_W = 3;
   localparam logic [STEP_CODE_W-1:0] S_CLEAR  = 3'd0;
   localparam logic [STEP_CODE_W-1:0] S_IDLE   = 3'd1;
   localparam logic [STEP_CODE_W-1:0] S_KMOD   = 3'd2;
   localparam logic [STEP_CODE_W-1:0] S_SLOAD  = 3'd3;
   localparam logic [STEP_CODE_W-1:0] S_SMOD   = 3'd4;
   localparam logic [STEP_CODE_W-1:0] S_ISSUE  = 3'd5;
   localparam logic [STEP_CODE_W-1:0] S_PROBE  = 3'd6;
   localparam logic [STEP_CODE_W-1:0] S_FINISH = 3'd7;

   // jump conditions: jump to target when true, hold the step when false
   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] C_ALWAYS     = 3'd0;
   localparam logic [COND_W-1:0] C_REQ        = 3'd1;
   localparam logic [COND_W-1:0] C_CLR_DONE   = 3'd3;
   localparam logic [COND_W-1:0] C_PROBE_DONE = 3'd4;
   localparam logic [COND_W-1:0] C_RSP_FREE   = 3'd5;

   typedef struct packed {
      logic [STEP_CODE_W-1:0] target;
      logic [COND_W-1:0]      cond;
      logic                   idle;
      logic                   clr_wr;
      logic                   key_ld;
      logic                   step_ld;
      logic                   issue;
      logic                   probe;
      logic                   finish;
   } ctl_type;

   typedef struct packed {
      logic req_go;
      logic clr_done;
      logic probe_done;
      logic rsp_free;
   } flg_type;

   function automatic ctl_type dht_rom(input logic [STEP_CODE_W-1:0] step);
      ctl_type w;
      w = '0;
      case (step)
         S_CLEAR: begin
            w.clr_wr = 1'b1;
            w.cond   = C_CLR_DONE;
            w.target = S_IDLE;
         end
         S_IDLE: begin
            w.idle    = 1'b1;
            w.key_ld  = 1'b1;
            w.cond    = C_REQ;
            w.target  = S_KMOD;
         end
         S_KMOD: begin
            w.cond   = C_ALWAYS;
            w.target = S_SLOAD;
         end
         S_SLOAD: begin
            w.step_ld = 1'b1;
            w.cond    = C_ALWAYS;
            w.target  = S_SMOD;
         end
         S_SMOD: begin
            w.cond   = C_ALWAYS;
            w.target = S_ISSUE;
         end
         S_ISSUE: begin
            w.issue  = 1'b1;
            w.cond   = C_ALWAYS;
            w.target = S_PROBE;
         end
         S_PROBE: begin
            w.probe  = 1'b1;
            w.cond   = C_PROBE_DONE;
            w.target = S_FINISH;
         end
         S_FINISH: begin
            w.finish = 1'b1;
            w.cond   = C_RSP_FREE;
            w.target = S_IDLE;
         end
         default: begin
            w.cond   = C_ALWAYS;
            w.target = S_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/core/dht_mod_unit.sv =====
module dht_mod_unit import dht_pkg::*; #(
   parameter int MODULUS = DEF_STEP_PRIME
) (
   input  logic                         clock,
   input  logic [OPND_W-1:0]            num,
   output logic [$clog2(MODULUS)-1:0]   rem
);

   localparam int RW = $clog2(MODULUS);
   localparam int SH = OPND_W + RW;
   localparam int PW = 2 * OPND_W + 1;
   localparam logic [63:0] ONE_SH = 64'd1 << SH;
   localparam logic [OPND_W:0] RECIP =
      (OPND_W+1)'((ONE_SH + 64'(MODULUS) - 64'd1) / 64'(MODULUS));
   localparam logic [RW-1:0] MOD_LO = RW'(MODULUS);

   logic [PW-1:0] prod;
   logic [RW-1:0] qlo_ff, qlo_in, qd;

   // quotient by reciprocal multiplication, exact for every operand word;
   // hold num until the remainder is used; the remainder follows the registered quotient
   assign prod   = PW'(num) * PW'(RECIP);
   assign qlo_in = prod[SH +: RW];

   always_ff @(posedge clock) begin
      qlo_ff <= qlo_in;
   end

   // the remainder fits in RW bits, so only the low bits of q * modulus matter
   assign qd  = qlo_ff * MOD_LO;
   assign rem = num[RW-1:0] - qd;

endmodule

// ===== rtl/core/dht_datapath.sv =====
module dht_datapath import dht_pkg::*; #(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int STEP_PRIME  = DEF_STEP_PRIME
) (
   input  logic              clock,
   input  logic              reset,
   input  ctl_type           ctl,
   output flg_type           flg,
   input  logic              req_valid,
   input  logic              req_kind,
   input  logic [KEY_W-1:0]  req_key,
   input  logic [VAL_W-1:0]  req_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [STAT_W-1:0] rsp_status,
   output logic [VAL_W-1:0]  rsp_found_value,
   output logic [SLOT_W-1:0] rsp_slot
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int PRM_W  = $clog2(STEP_PRIME);
   localparam int WORD_W = 1 + KEY_W + VAL_W;

   logic              kind_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [VAL_W-1:0]  value_ff;
   logic [OPND_W-1:0] opnd_ff;
   logic [IDX_W-1:0]  clr_ff;
   logic [IDX_W-1:0]  start_ff;
   logic [IDX_W-1:0]  stepd_ff;
   logic [IDX_W-1:0]  idx_ff;

   logic [STAT_W-1:0] res_status_ff;
   logic [VAL_W-1:0]  res_value_ff;
   logic [SLOT_W-1:0] res_slot_ff;
   logic              wr_need_ff;

   logic              rsp_valid_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [VAL_W-1:0]  rsp_value_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;

   logic [WORD_W-1:0] slot_mem_ff [TABLE_DEPTH];
   logic [WORD_W-1:0] mem_rd_ff;

   logic              req_go, finish_go, mem_we;
   logic [IDX_W-1:0]  rem_d;
   logic [PRM_W-1:0]  rem_p;
   logic [STEP_W-1:0] step_raw;
   logic [IDX_W:0]    sum;
   logic [IDX_W-1:0]  nxt, rd_addr, mem_wa;
   logic [WORD_W-1:0] mem_wd;
   logic              rd_used, rd_match, wrap, done;
   logic [KEY_W-1:0]  rd_key;
   logic [VAL_W-1:0]  rd_value;

   assign req_go    = req_valid & ctl.idle;
   assign finish_go = ctl.finish & (~rsp_valid_ff | rsp_ready);

   dht_mod_unit #(.MODULUS(TABLE_DEPTH)) u_mod_depth (
      .clock (clock),
      .num   (opnd_ff),
      .rem   (rem_d)
   );

   dht_mod_unit #(.MODULUS(STEP_PRIME)) u_mod_prime (
      .clock (clock),
      .num   (opnd_ff),
      .rem   (rem_p)
   );

   assign step_raw = STEP_W'(STEP_PRIME) - STEP_W'(rem_p);

   // next probe slot, step already reduced below the depth
   assign sum = {1'b0, idx_ff} + {1'b0, stepd_ff};
   assign nxt = (sum >= (IDX_W+1)'(TABLE_DEPTH)) ?
                IDX_W'(sum - (IDX_W+1)'(TABLE_DEPTH)) : sum[IDX_W-1:0];

   assign rd_used  = mem_rd_ff[WORD_W-1];
   assign rd_key   = mem_rd_ff[KEY_W+VAL_W-1:VAL_W];
   assign rd_value = mem_rd_ff[VAL_W-1:0];
   assign rd_match = rd_used & (rd_key == key_ff);
   assign wrap     = (nxt == start_ff);
   assign done     = ~rd_used | rd_match | wrap;

   assign rd_addr = ctl.issue ? start_ff : nxt;
   assign mem_we  = ctl.clr_wr | (finish_go & wr_need_ff);
   assign mem_wa  = ctl.clr_wr ? clr_ff : idx_ff;
   assign mem_wd  = ctl.clr_wr ? '0 : {1'b1, key_ff, value_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem_ff[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= slot_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (req_go) begin
         kind_ff  <= req_kind;
         key_ff   <= req_key;
         value_ff <= req_value;
         opnd_ff  <= req_key;
      end else if (ctl.step_ld) begin
         opnd_ff <= {{(OPND_W-STEP_W){1'b0}}, step_raw};
      end

      if (ctl.step_ld) begin
         start_ff <= rem_d;
      end
      if (ctl.issue) begin
         stepd_ff <= rem_d;
         idx_ff   <= start_ff;
      end else if (ctl.probe && !done) begin
         idx_ff <= nxt;
      end

      if (ctl.probe && done) begin
         res_value_ff <= '0;
         res_slot_ff  <= '0;
         wr_need_ff   <= 1'b0;
         if (!rd_used) begin
            if (kind_ff == KIND_INSERT) begin
               res_status_ff <= ST_INSERTED;
               res_slot_ff   <= SLOT_W'(idx_ff);
               wr_need_ff    <= 1'b1;
            end else begin
               res_status_ff <= ST_NOT_FOUND;
            end
         end else if (rd_match) begin
            res_slot_ff <= SLOT_W'(idx_ff);
            if (kind_ff == KIND_INSERT) begin
               res_status_ff <= ST_UPDATED;
               wr_need_ff    <= 1'b1;
            end else begin
               res_status_ff <= ST_FOUND;
               res_value_ff  <= rd_value;
            end
         end else begin
            res_status_ff <= (kind_ff == KIND_INSERT) ? ST_FULL : ST_NOT_FOUND;
         end
      end

      if (finish_go) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
         rsp_slot_ff   <= res_slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctl.clr_wr) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (finish_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign flg.req_go     = req_go;
   assign flg.clr_done   = (clr_ff == IDX_W'(TABLE_DEPTH - 1));
   assign flg.probe_done = done;
   assign flg.rsp_free   = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_value_ff;
   assign rsp_slot        = rsp_slot_ff;

   a_value_only_on_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_FOUND) |-> (rsp_value_ff == '0))
      else $error("found_value nonzero without a hit");

   a_slot_zero_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_NOT_FOUND || rsp_status_ff == ST_FULL))
      |-> (rsp_slot_ff == '0))
      else $error("slot nonzero on miss or full");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctl.finish))
      else $error("response raised outside finish step");

endmodule

// ===== rtl/core/dht_sequencer.sv =====
module dht_sequencer import dht_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  flg_type flg,
   output ctl_type ctl
);

   logic [STEP_CODE_W-1:0] step_ff, step_in;
   logic                   jump;

   assign ctl = dht_rom(step_ff);

   // jump when the selected condition holds, else hold the step
   always_comb begin
      case (ctl.cond)
         C_ALWAYS:     jump = 1'b1;
         C_REQ:        jump = flg.req_go;
         C_CLR_DONE:   jump = flg.clr_done;
         C_PROBE_DONE: jump = flg.probe_done;
         C_RSP_FREE:   jump = flg.rsp_free;
         default:      jump = 1'b1;
      endcase
      step_in = jump ? ctl.target : step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_CLEAR;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== rtl/core/double_hash_table.sv =====
// A word accepted on req raises rsp_valid after the hash setup steps, P probes and
// finish, where P is the probe count (1 up to the probe cycle length, at most TABLE_DEPTH).
// A new word is taken only once the previous one has finished; the probe loop reads one slot
// per cycle from the single-read-port slot memory, after the kmod, sload, smod and issue steps.
// Reset: synchronous, active high; afterwards a clearing pass empties every slot while
// req_ready stays low.
module double_hash_table import dht_pkg::*; #(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int STEP_PRIME  = DEF_STEP_PRIME
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic [KEY_W-1:0]  req_key,
   input  logic [VAL_W-1:0]  req_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [STAT_W-1:0] rsp_status,
   output logic [VAL_W-1:0]  rsp_found_value,
   output logic [SLOT_W-1:0] rsp_slot
);

   // The sequencer steps through a small microprogram held in dht_rom:
   //   clear   - write an empty word into one slot per cycle after reset
   //   idle    - take a request word, load the key into the operand register
   //   kmod    - multiply the key by both reciprocals, register the quotients
   //   sload   - latch start slot, form step = prime - (key mod prime)
   //   smod    - quotient of the step by the table depth
   //   issue   - latch the step below the depth, read the start slot
   //   probe   - one slot per cycle until empty, match or back at start
   //   finish  - write back on insert/update, post the response word
   // The response register parts the two sides: a finished word may wait on
   // rsp_ready while the next request is taken; finish only holds when the
   // response register is still occupied.

   ctl_type ctl;
   flg_type flg;

   dht_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flg   (flg),
      .ctl   (ctl)
   );

   dht_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .STEP_PRIME  (STEP_PRIME)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .flg             (flg),
      .req_valid       (req_valid),
      .req_kind        (req_kind),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_value (rsp_found_value),
      .rsp_slot        (rsp_slot)
   );

   // accept a request word only in the idle step
   assign req_ready = ctl.idle;

endmodule
